// ===== src/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants for the adaptive replacement cache page replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

  localparam int PAGE_BITS      = 31;
  localparam int NUM_FRAMES_DEF = 64;
  localparam int FI_W           = 6;
  localparam int FIU_W          = 7;
  localparam int TOT_W          = 7;
  localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

  typedef enum logic [1:0] {
    REQ_ACCESS    = 2'd0,
    REQ_SET_EVICT = 2'd1,
    REQ_EVICT     = 2'd2,
    REQ_REMOVE    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    LST_REC = 2'd0,
    LST_FRQ = 2'd1,
    LST_RGH = 2'd2,
    LST_FGH = 2'd3
  } list_id_t;

  typedef enum logic [1:0] {
    WK_FIND = 2'd0,
    WK_VIC  = 2'd1,
    WK_DROP = 2'd2,
    WK_PUSH = 2'd3
  } walk_mode_t;

  typedef enum logic [1:0] {
    W_IDLE = 2'd0,
    W_RUN  = 2'd1,
    W_LAST = 2'd2,
    W_DONE = 2'd3
  } walk_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PAGE,
    S_UNL_FIND,
    S_UNL_DROP,
    S_GH_RFIND,
    S_GH_FFIND,
    S_GH_DROP,
    S_DIV,
    S_ADAPT,
    S_COLD,
    S_INSTALL,
    S_VIC_SCAN,
    S_VIC_DROP,
    S_VIC_PUSH,
    S_FINISH
  } arc_state_t;

  typedef struct packed {
    logic       go;
    walk_mode_t mode;
    list_id_t   lst;
  } walk_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } walk_res_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [FI_W-1:0]      frame_index;
    logic [PAGE_BITS-1:0] page_number;
    logic                 evictable_flag;
  } arc_req_t;

  typedef struct packed {
    logic             victim_valid;
    logic [FI_W-1:0]  victim_frame;
    logic [TOT_W-1:0] evictable_total;
  } arc_rsp_t;

endpackage

`default_nettype wire

// ===== src/arc_page_replacer_core.sv =====
// ----------------------------------------------------------------------------
// arc_page_replacer_core
// Adaptive replacement cache bookkeeping for buffer frames.
// ----------------------------------------------------------------------------
// A request enters on req_valid/req_stall and carries a type, a frame, a page
// and an evictable flag. Every request gives exactly one response on
// rsp_valid/rsp_stall: victim flag, victim frame and the evictable count.
// frames_in_use must be written on cfg_valid/cfg_ready only while no request
// is active; the core does not enforce this. One request is worked on at a
// time; req_stall stays high until it is done. Set evictable and an ignored
// request take no list work; remove runs an unlink; evict runs up to two
// victim scans, one remove-at and one ghost push; access runs up to an
// unlink, two ghost searches, a remove-at, a divide and a push. All list
// work runs through one list walker that touches one memory entry per cycle.
// Reset clears all control state, list lengths, target and count, and sets
// frames_in_use to 64. While the receiver stalls, the
// finished response is held and the next request may already be taken and
// worked on; it waits before its response until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_page_replacer_core #(
  parameter int NUM_FRAMES = arc_pkg::NUM_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  arc_pkg::arc_req_t            req_data,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output arc_pkg::arc_rsp_t            rsp_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [arc_pkg::FIU_W-1:0]    cfg_data
);
  import arc_pkg::*;

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int SUM_W = CNT_W + 2;
  localparam logic [CNT_W-1:0] FULL    = CNT_W'(NUM_FRAMES);
  localparam logic [CNT_W-1:0] FULL_M1 = CNT_W'(NUM_FRAMES - 1);

  arc_state_t state, state_next;

  logic [FIU_W-1:0]      frames_in_use;
  logic [NUM_FRAMES-1:0] resident;
  logic [NUM_FRAMES-1:0] pinned;
  logic [NUM_FRAMES-1:0] in_freq;
  logic [CNT_W-1:0]      len_rec, len_frq, len_rgh, len_fgh;
  logic [CNT_W-1:0]      target;
  logic [CNT_W-1:0]      evcount;
  arc_req_t              req;
  logic                  unl_freq, hit, gh_rec, inst_freq;
  logic                  vic_freq, vic_second, vic_ok;
  logic [IDX_W-1:0]      vic_frame;
  logic [IDX_W-1:0]      pos_r;
  logic [CNT_W-1:0]      lr_s, lf_s, step;

  logic [PAGE_BITS-1:0]  page_mem [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  page_rd;
  logic [IDX_W-1:0]      page_raddr;

  walk_cmd_t             wk_cmd;
  walk_res_t             wk_res;
  logic [PAGE_BITS-1:0]  wk_key;
  logic [CNT_W-1:0]      wk_len;
  logic [CNT_W-1:0]      cur_len;
  logic [IDX_W-1:0]      wk_hit_pos;
  logic [PAGE_BITS-1:0]  wk_hit_val;

  logic                  div_go, div_done;
  logic [CNT_W-1:0]      div_num, div_den, div_q;

  logic [IDX_W-1:0]      fidx;
  logic                  f_ok, in_budget, f_res, f_pin, f_frq, page_hit;
  logic [CNT_W-1:0]      budget, ev_dec;
  arc_state_t            after_unl;
  logic                  need_div;
  logic [SUM_W-1:0]      sum_rr, sum_all, two_b, up_sum;
  logic [CNT_W-1:0]      target_up, target_dn;
  logic                  len_we;
  logic [CNT_W-1:0]      len_new;

  assign cfg_ready = 1'b1;

  assign fidx      = IDX_W'(req.frame_index);
  assign f_ok      = 32'(req.frame_index) < 32'(NUM_FRAMES);
  assign budget    = (32'(frames_in_use) > 32'(NUM_FRAMES)) ? FULL : CNT_W'(frames_in_use);
  assign in_budget = 32'(req.frame_index) < 32'(budget);
  assign f_res     = f_ok && resident[fidx];
  assign f_pin     = pinned[fidx];
  assign f_frq     = in_freq[fidx];
  assign page_hit  = f_res && (page_rd == req.page_number);
  assign ev_dec    = (evcount != '0) ? evcount - 1'b1 : '0;

  assign after_unl = (req.req_type == REQ_REMOVE) ? S_FINISH : (hit ? S_INSTALL : S_GH_RFIND);

  assign need_div = gh_rec ? ((lr_s < lf_s) && (lr_s != '0)) : ((lf_s < lr_s) && (lf_s != '0));
  assign div_num  = gh_rec ? lf_s : lr_s;
  assign div_den  = gh_rec ? lr_s : lf_s;

  assign sum_rr    = SUM_W'(len_rec) + SUM_W'(len_rgh);
  assign sum_all   = sum_rr + SUM_W'(len_frq) + SUM_W'(len_fgh);
  assign two_b     = SUM_W'(budget) << 1;
  assign up_sum    = SUM_W'(target) + SUM_W'(step);
  assign target_up = (up_sum > SUM_W'(budget)) ? budget : CNT_W'(up_sum);
  assign target_dn = (target > step) ? target - step : '0;

  always_comb begin
    case (wk_cmd.lst)
      LST_REC: cur_len = len_rec;
      LST_FRQ: cur_len = len_frq;
      LST_RGH: cur_len = len_rgh;
      default: cur_len = len_fgh;
    endcase
  end

  assign wk_len  = (wk_cmd.mode == WK_PUSH && cur_len >= FULL) ? FULL_M1 : cur_len;
  assign len_we  = wk_res.done && (state == S_UNL_DROP || state == S_GH_DROP ||
                   state == S_VIC_DROP || state == S_INSTALL || state == S_VIC_PUSH);
  assign len_new = (wk_cmd.mode == WK_PUSH) ? wk_len + 1'b1 : cur_len - 1'b1;

  arc_walk #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .cmd     (wk_cmd),
    .key     (wk_key),
    .pos     (pos_r),
    .len     (wk_len),
    .pinned  (pinned),
    .res     (wk_res),
    .hit_pos (wk_hit_pos),
    .hit_val (wk_hit_val)
  );

  arc_div #(
    .W (CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (req.req_type)
          REQ_ACCESS:    state_next = (f_ok && in_budget) ? S_PAGE : S_FINISH;
          REQ_SET_EVICT: state_next = S_FINISH;
          REQ_EVICT:     state_next = S_VIC_SCAN;
          default:       state_next = (f_res && f_pin) ? S_UNL_FIND : S_FINISH;
        endcase
      end
      S_PAGE: state_next = f_res ? S_UNL_FIND : S_GH_RFIND;
      S_UNL_FIND: begin
        if (wk_res.done) state_next = wk_res.found ? S_UNL_DROP : after_unl;
      end
      S_UNL_DROP: begin
        if (wk_res.done) state_next = after_unl;
      end
      S_GH_RFIND: begin
        if (wk_res.done) state_next = wk_res.found ? S_GH_DROP : S_GH_FFIND;
      end
      S_GH_FFIND: begin
        if (wk_res.done) state_next = wk_res.found ? S_GH_DROP : S_COLD;
      end
      S_GH_DROP: begin
        if (wk_res.done) state_next = need_div ? S_DIV : S_ADAPT;
      end
      S_DIV: begin
        if (div_done) state_next = S_ADAPT;
      end
      S_ADAPT: state_next = S_INSTALL;
      S_COLD:  state_next = S_INSTALL;
      S_INSTALL: begin
        if (wk_res.done) state_next = S_FINISH;
      end
      S_VIC_SCAN: begin
        if (wk_res.done) begin
          if (wk_res.found) state_next = S_VIC_DROP;
          else state_next = vic_second ? S_FINISH : S_VIC_SCAN;
        end
      end
      S_VIC_DROP: begin
        if (wk_res.done) state_next = S_VIC_PUSH;
      end
      S_VIC_PUSH: begin
        if (wk_res.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_stall   = 1'b1;
    wk_cmd.go   = 1'b0;
    wk_cmd.mode = WK_FIND;
    wk_cmd.lst  = LST_REC;
    wk_key      = PAGE_BITS'(fidx);
    page_raddr  = fidx;
    div_go      = 1'b0;
    unique case (state)
      S_IDLE: req_stall = 1'b0;
      S_UNL_FIND: begin
        wk_cmd.go  = 1'b1;
        wk_cmd.lst = unl_freq ? LST_FRQ : LST_REC;
      end
      S_UNL_DROP: begin
        wk_cmd.go   = 1'b1;
        wk_cmd.mode = WK_DROP;
        wk_cmd.lst  = unl_freq ? LST_FRQ : LST_REC;
      end
      S_GH_RFIND: begin
        wk_cmd.go  = 1'b1;
        wk_cmd.lst = LST_RGH;
        wk_key     = req.page_number;
      end
      S_GH_FFIND: begin
        wk_cmd.go  = 1'b1;
        wk_cmd.lst = LST_FGH;
        wk_key     = req.page_number;
      end
      S_GH_DROP: begin
        wk_cmd.go   = 1'b1;
        wk_cmd.mode = WK_DROP;
        wk_cmd.lst  = gh_rec ? LST_RGH : LST_FGH;
      end
      S_DIV: div_go = 1'b1;
      S_INSTALL: begin
        wk_cmd.go   = 1'b1;
        wk_cmd.mode = WK_PUSH;
        wk_cmd.lst  = inst_freq ? LST_FRQ : LST_REC;
      end
      S_VIC_SCAN: begin
        wk_cmd.go   = 1'b1;
        wk_cmd.mode = WK_VIC;
        wk_cmd.lst  = vic_freq ? LST_FRQ : LST_REC;
      end
      S_VIC_DROP: begin
        wk_cmd.go   = 1'b1;
        wk_cmd.mode = WK_DROP;
        wk_cmd.lst  = vic_freq ? LST_FRQ : LST_REC;
        page_raddr  = vic_frame;
      end
      S_VIC_PUSH: begin
        wk_cmd.go   = 1'b1;
        wk_cmd.mode = WK_PUSH;
        wk_cmd.lst  = vic_freq ? LST_FGH : LST_RGH;
        wk_key      = page_rd;
        page_raddr  = vic_frame;
      end
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_in_use <= FIU_RESET;
      resident      <= '0;
      pinned        <= '0;
      in_freq       <= '0;
      len_rec       <= '0;
      len_frq       <= '0;
      len_rgh       <= '0;
      len_fgh       <= '0;
      target        <= '0;
      evcount       <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) frames_in_use <= cfg_data;

      if (state == S_FINISH && state_next == S_IDLE) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;

      if (len_we) begin
        case (wk_cmd.lst)
          LST_REC: len_rec <= len_new;
          LST_FRQ: len_frq <= len_new;
          LST_RGH: len_rgh <= len_new;
          default: len_fgh <= len_new;
        endcase
      end

      case (state)
        S_DECODE: begin
          if (req.req_type == REQ_SET_EVICT && f_res && (f_pin != req.evictable_flag)) begin
            pinned[fidx] <= req.evictable_flag;
            evcount      <= req.evictable_flag ? evcount + 1'b1 : ev_dec;
          end
          if (req.req_type == REQ_REMOVE && f_res && f_pin) begin
            resident[fidx] <= 1'b0;
            pinned[fidx]   <= 1'b0;
            in_freq[fidx]  <= 1'b0;
            evcount        <= ev_dec;
          end
        end
        S_PAGE: begin
          // a different page in a resident frame drops it first
          if (f_res && !page_hit) begin
            if (f_pin) evcount <= ev_dec;
            resident[fidx] <= 1'b0;
            pinned[fidx]   <= 1'b0;
            in_freq[fidx]  <= 1'b0;
          end
        end
        S_ADAPT: target <= gh_rec ? target_up : target_dn;
        S_COLD: begin
          if (sum_rr == SUM_W'(budget)) begin
            if (len_rgh != '0) len_rgh <= len_rgh - 1'b1;
          end else if (sum_all == two_b && len_fgh != '0) begin
            len_fgh <= len_fgh - 1'b1;
          end
        end
        S_INSTALL: begin
          if (wk_res.done) begin
            resident[fidx] <= 1'b1;
            in_freq[fidx]  <= inst_freq;
          end
        end
        S_VIC_PUSH: begin
          if (wk_res.done) begin
            resident[vic_frame] <= 1'b0;
            pinned[vic_frame]   <= 1'b0;
            in_freq[vic_frame]  <= 1'b0;
            evcount             <= ev_dec;
          end
        end
        default: ;
      endcase
    end
  end

  // request context and walk bookkeeping
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) req <= req_data;
      end
      S_DECODE: begin
        vic_ok     <= 1'b0;
        vic_frame  <= '0;
        unl_freq   <= f_frq;
        vic_freq   <= !(len_rec >= target);
        vic_second <= 1'b0;
      end
      S_PAGE: begin
        hit       <= page_hit;
        lr_s      <= len_rgh;
        lf_s      <= len_fgh;
        inst_freq <= 1'b1;
      end
      S_UNL_FIND: begin
        if (wk_res.done && wk_res.found) pos_r <= wk_hit_pos;
      end
      S_GH_RFIND: begin
        if (wk_res.done && wk_res.found) begin
          gh_rec <= 1'b1;
          pos_r  <= wk_hit_pos;
        end
      end
      S_GH_FFIND: begin
        if (wk_res.done && wk_res.found) begin
          gh_rec <= 1'b0;
          pos_r  <= wk_hit_pos;
        end
      end
      S_GH_DROP: step <= CNT_W'(1);
      S_DIV: begin
        if (div_done) step <= div_q;
      end
      S_COLD: inst_freq <= 1'b0;
      S_VIC_SCAN: begin
        if (wk_res.done) begin
          if (wk_res.found) begin
            vic_frame <= IDX_W'(wk_hit_val);
            pos_r     <= wk_hit_pos;
          end else begin
            vic_second <= 1'b1;
            vic_freq   <= !vic_freq;
          end
        end
      end
      S_VIC_PUSH: begin
        if (wk_res.done) vic_ok <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && state_next == S_IDLE) begin
      rsp_data.victim_valid    <= vic_ok;
      rsp_data.victim_frame    <= FI_W'(vic_frame);
      rsp_data.evictable_total <= TOT_W'(evcount);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_INSTALL && wk_res.done) page_mem[fidx] <= req.page_number;
    page_rd <= page_mem[page_raddr];
  end

  a_walk_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wk_res.busy)
    else $error("list walker busy with no request in progress");

  a_resident_len: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(len_rec) + SUM_W'(len_frq)) <= SUM_W'(NUM_FRAMES))
    else $error("resident lists longer than the frame count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    evcount <= FULL)
    else $error("evictable count above frame count");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FINISH)
    else $error("response raised outside the finish step");

endmodule

`default_nettype wire

// ===== src/arc_div.sv =====
// ----------------------------------------------------------------------------
// arc_div
// Restoring divider, one quotient bit per cycle, for the target adaptation step.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_div #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic         busy;
  logic         fin;
  logic [CW-1:0] cnt;
  logic [W-1:0] rem;
  logic [W-1:0] qa;
  logic [W:0]   trial;
  logic         ge;

  assign trial = {rem, qa[W-1]};
  assign ge    = trial >= {1'b0, den};
  assign done  = fin;
  assign quo   = qa;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (!busy && !fin && go) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && !fin && go) begin
      rem <= '0;
      qa  <= num;
    end else if (busy) begin
      rem <= ge ? W'(trial - {1'b0, den}) : trial[W-1:0];
      qa  <= {qa[W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== src/arc_walk.sv =====
// ----------------------------------------------------------------------------
// arc_walk
// List walker: holds the four ordered lists in one memory and runs search,
// victim scan, remove-at and push-front over them, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_walk #(
  parameter int NUM_FRAMES = arc_pkg::NUM_FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  arc_pkg::walk_cmd_t                 cmd,
  input  logic [arc_pkg::PAGE_BITS-1:0]      key,
  input  logic [$clog2(NUM_FRAMES)-1:0]      pos,
  input  logic [$clog2(NUM_FRAMES+1)-1:0]    len,
  input  logic [NUM_FRAMES-1:0]              pinned,
  output arc_pkg::walk_res_t                 res,
  output logic [$clog2(NUM_FRAMES)-1:0]      hit_pos,
  output logic [arc_pkg::PAGE_BITS-1:0]      hit_val
);
  import arc_pkg::*;

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int AW    = IDX_W + 2;
  localparam int DEPTH = 4 * (1 << IDX_W);

  walk_state_t state, state_next;

  logic [PAGE_BITS-1:0] lmem [DEPTH];
  logic [PAGE_BITS-1:0] rdata;

  logic [CNT_W-1:0] ridx;
  logic [IDX_W-1:0] pidx;
  logic             pend;
  logic             found;

  logic             is_push;
  logic             rd_ok;
  logic [IDX_W-1:0] rd_idx;
  logic             match;
  logic             pin_hit;
  logic             stop_find;
  logic             scan_end;
  logic             issue;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [PAGE_BITS-1:0] wdata;

  assign is_push   = cmd.mode == WK_PUSH;
  assign rd_ok     = is_push ? (ridx != '0) : (ridx < len);
  assign rd_idx    = is_push ? IDX_W'(ridx - 1'b1) : ridx[IDX_W-1:0];
  assign match     = pend && (rdata == key);
  assign pin_hit   = pend && (rdata < PAGE_BITS'(NUM_FRAMES)) && pinned[rdata[IDX_W-1:0]];
  assign stop_find = (cmd.mode == WK_FIND) && (found || match);
  assign scan_end  = !rd_ok && !pend;
  assign issue     = (state == W_RUN) && rd_ok && !stop_find;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      W_IDLE: begin
        if (cmd.go) state_next = W_RUN;
      end
      W_RUN: begin
        if (stop_find) state_next = W_DONE;
        else if (scan_end) state_next = is_push ? W_LAST : W_DONE;
      end
      W_LAST: state_next = W_DONE;
      W_DONE: state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    we    = 1'b0;
    waddr = {cmd.lst, rd_idx};
    wdata = rdata;
    unique case (state)
      W_RUN: begin
        if (pend && (cmd.mode == WK_DROP)) begin
          we    = 1'b1;
          waddr = {cmd.lst, IDX_W'(pidx - 1'b1)};
        end else if (pend && is_push) begin
          we    = 1'b1;
          waddr = {cmd.lst, IDX_W'(pidx + 1'b1)};
        end
      end
      W_LAST: begin
        we    = 1'b1;
        waddr = {cmd.lst, IDX_W'(0)};
        wdata = key;
      end
      default: we = 1'b0;
    endcase
  end

  assign res.busy  = state != W_IDLE;
  assign res.done  = state == W_DONE;
  assign res.found = found;

  always_ff @(posedge clk) begin
    if (rst) state <= W_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == W_IDLE && cmd.go) begin
      pend  <= 1'b0;
      found <= 1'b0;
      unique case (cmd.mode)
        WK_DROP: ridx <= CNT_W'(pos) + 1'b1;
        WK_PUSH: ridx <= len;
        default: ridx <= '0;
      endcase
    end else if (state == W_RUN) begin
      pend <= issue;
      if (issue) begin
        pidx <= rd_idx;
        ridx <= is_push ? ridx - 1'b1 : ridx + 1'b1;
      end
      if ((cmd.mode == WK_FIND && match && !found) || (cmd.mode == WK_VIC && pin_hit)) begin
        found   <= 1'b1;
        hit_pos <= pidx;
        hit_val <= rdata;
      end
    end else begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) lmem[waddr] <= wdata;
    rdata <= lmem[{cmd.lst, rd_idx}];
  end

endmodule

`default_nettype wire
